FILE: sv/sktms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sktms_pkg
// Shared types and constants for the sorted key table with mark and sweep.
// ----------------------------------------------------------------------------
package sktms_pkg;

	localparam int POS_W = 6;
	localparam int TOT_W = 7;

	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_TOUCH  = 2'd1;
	localparam logic [1:0] FUNC_ROUND  = 2'd2;
	localparam logic [1:0] FUNC_SWEEP  = 2'd3;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INSERT,
		CELL_MARK,
		CELL_CLR,
		CELL_KILL,
		CELL_SWAP_EVEN,
		CELL_SWAP_ODD
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_APPLY,
		S_ROUND,
		S_KILL,
		S_SWAP,
		S_COUNT
	} state_t;

	typedef struct packed {
		logic valid;
		logic fresh;
		logic lt;
	} cell_nb_t;

endpackage
`default_nettype wire

FILE: sv/sktms_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sktms_cell
// One table slot: key, valid and fresh bits, compare flags, and the moves
// to and from its neighbors for insert shift and sweep compaction.
// ----------------------------------------------------------------------------
module sktms_cell #(
	parameter int       KEY_BITS = 22,
	parameter bit       PARITY   = 1'b0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  sktms_pkg::cell_op_t       op,
	input  wire  [KEY_BITS-1:0]       cmd_key,
	input  wire  [KEY_BITS-1:0]       left_key,
	input  sktms_pkg::cell_nb_t       left_nb,
	input  wire  [KEY_BITS-1:0]       right_key,
	input  sktms_pkg::cell_nb_t       right_nb,
	output logic [KEY_BITS-1:0]       key_out,
	output sktms_pkg::cell_nb_t       nb_out,
	output logic                      eq_out
);

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic                fresh_q;
	logic                lt_q;
	logic                eq_q;
	logic                lead;
	logic                is_pos;

	assign lead = (op == sktms_pkg::CELL_SWAP_EVEN && PARITY == 1'b0) ||
	              (op == sktms_pkg::CELL_SWAP_ODD  && PARITY == 1'b1);
	assign is_pos = !lt_q && left_nb.lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			fresh_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			case (op)
				sktms_pkg::CELL_CMP: begin
					lt_q <= valid_q && (key_q < cmd_key);
					eq_q <= valid_q && (key_q == cmd_key);
				end
				sktms_pkg::CELL_INSERT: begin
					if (is_pos) begin
						valid_q <= 1'b1;
						fresh_q <= 1'b1;
					end else if (!lt_q) begin
						valid_q <= left_nb.valid;
						fresh_q <= left_nb.fresh;
					end
				end
				sktms_pkg::CELL_MARK: begin
					if (eq_q) begin
						fresh_q <= 1'b1;
					end
				end
				sktms_pkg::CELL_CLR: begin
					fresh_q <= 1'b0;
				end
				sktms_pkg::CELL_KILL: begin
					valid_q <= valid_q && fresh_q;
					fresh_q <= valid_q && fresh_q;
				end
				sktms_pkg::CELL_SWAP_EVEN, sktms_pkg::CELL_SWAP_ODD: begin
					if (lead) begin
						if (!valid_q && right_nb.valid) begin
							valid_q <= 1'b1;
							fresh_q <= right_nb.fresh;
						end
					end else if (!left_nb.valid && valid_q) begin
						valid_q <= 1'b0;
						fresh_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// key payload, no reset
	always_ff @(posedge clk) begin
		case (op)
			sktms_pkg::CELL_INSERT: begin
				if (is_pos) begin
					key_q <= cmd_key;
				end else if (!lt_q) begin
					key_q <= left_key;
				end
			end
			sktms_pkg::CELL_SWAP_EVEN, sktms_pkg::CELL_SWAP_ODD: begin
				if (lead && !valid_q && right_nb.valid) begin
					key_q <= right_key;
				end
			end
			default: begin
			end
		endcase
	end

	assign key_out      = key_q;
	assign nb_out.valid = valid_q;
	assign nb_out.fresh = fresh_q;
	assign nb_out.lt    = lt_q;
	assign eq_out       = eq_q;

endmodule
`default_nettype wire

FILE: sv/sorted_key_table_mark_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_mark_sweep
// Sorted key table held in a row of cells; lookup, touch/insert, new round,
// and sweep of stale entries with order-keeping compaction.
// ----------------------------------------------------------------------------
// Steps from accept to done: lookup and touch pass S_CMP and S_APPLY, round
// passes S_ROUND, and sweep passes S_KILL, DEPTH odd-even compaction phases
// along the row, then S_COUNT; done is registered. A new item can be accepted
// in the cycle that done is high; no new item is taken while one is in work.
// Results are single-cycle strobes; the receiver cannot stall.
// Reset leaves the table empty with all marks clear; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_table_mark_sweep #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 22
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [1:0]                       func,
	input  wire  [KEY_BITS-1:0]              key,
	output logic                             done,
	output logic                             found,
	output logic [sktms_pkg::POS_W-1:0]      position,
	output logic [sktms_pkg::TOT_W-1:0]      entry_total,
	output logic                             full_drop
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH);

	sktms_pkg::state_t   state_q, state_d;
	sktms_pkg::cell_op_t cell_op;

	logic [1:0]          func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       count_q;
	logic [SW-1:0]       sweep_cnt_q;

	logic                             done_q;
	logic                             found_q;
	logic [sktms_pkg::POS_W-1:0]      position_q;
	logic [sktms_pkg::TOT_W-1:0]      total_q;
	logic                             drop_q;

	logic [KEY_BITS-1:0]  cell_key [DEPTH];
	sktms_pkg::cell_nb_t  cell_nb  [DEPTH];
	logic [DEPTH-1:0]     lt_vec;
	logic [DEPTH-1:0]     eq_vec;
	logic [DEPTH-1:0]     valid_vec;

	logic [DEPTH-1:0]     enc_src;
	logic [DEPTH-1:0]     enc_hit;
	logic [CW-1:0]        enc_val;
	logic                 hit;
	logic                 full;
	logic                 ins;
	logic                 accept;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [KEY_BITS-1:0] lk, rk;
			sktms_pkg::cell_nb_t ln, rn;
			if (gi == 0) begin : g_first
				assign lk = '0;
				assign ln = '{valid: 1'b1, fresh: 1'b0, lt: 1'b1};
			end else begin : g_mid_l
				assign lk = cell_key[gi-1];
				assign ln = cell_nb[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign rk = '0;
				assign rn = '{valid: 1'b0, fresh: 1'b0, lt: 1'b0};
			end else begin : g_mid_r
				assign rk = cell_key[gi+1];
				assign rn = cell_nb[gi+1];
			end
			sktms_cell #(
				.KEY_BITS (KEY_BITS),
				.PARITY   (1'(gi % 2))
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.op        (cell_op),
				.cmd_key   (key_q),
				.left_key  (lk),
				.left_nb   (ln),
				.right_key (rk),
				.right_nb  (rn),
				.key_out   (cell_key[gi]),
				.nb_out    (cell_nb[gi]),
				.eq_out    (eq_vec[gi])
			);
			assign lt_vec[gi]    = cell_nb[gi].lt;
			assign valid_vec[gi] = cell_nb[gi].valid;
		end
	endgenerate

	// leading-ones count of a thermometer vector
	always_comb begin
		enc_src = (state_q == sktms_pkg::S_COUNT) ? valid_vec : lt_vec;
		enc_hit = enc_src & ~(enc_src >> 1);
		enc_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (enc_hit[i]) begin
				enc_val = enc_val | CW'(i + 1);
			end
		end
	end

	assign hit    = |eq_vec;
	assign full   = (count_q == CW'(DEPTH));
	assign ins    = (func_q == sktms_pkg::FUNC_TOUCH) && !hit && !full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sktms_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cell_op = sktms_pkg::CELL_HOLD;
		busy    = (state_q != sktms_pkg::S_IDLE);
		case (state_q)
			sktms_pkg::S_IDLE: begin
				if (start) begin
					case (func)
						sktms_pkg::FUNC_LOOKUP, sktms_pkg::FUNC_TOUCH: begin
							state_d = sktms_pkg::S_CMP;
						end
						sktms_pkg::FUNC_ROUND: begin
							state_d = sktms_pkg::S_ROUND;
						end
						default: begin
							state_d = sktms_pkg::S_KILL;
						end
					endcase
				end
			end
			sktms_pkg::S_CMP: begin
				cell_op = sktms_pkg::CELL_CMP;
				state_d = sktms_pkg::S_APPLY;
			end
			sktms_pkg::S_APPLY: begin
				if (func_q == sktms_pkg::FUNC_TOUCH) begin
					cell_op = ins ? sktms_pkg::CELL_INSERT : sktms_pkg::CELL_MARK;
				end
				state_d = sktms_pkg::S_IDLE;
			end
			sktms_pkg::S_ROUND: begin
				cell_op = sktms_pkg::CELL_CLR;
				state_d = sktms_pkg::S_IDLE;
			end
			sktms_pkg::S_KILL: begin
				cell_op = sktms_pkg::CELL_KILL;
				state_d = sktms_pkg::S_SWAP;
			end
			sktms_pkg::S_SWAP: begin
				cell_op = sweep_cnt_q[0] ? sktms_pkg::CELL_SWAP_ODD
				                         : sktms_pkg::CELL_SWAP_EVEN;
				if (sweep_cnt_q == SW'(DEPTH - 1)) begin
					state_d = sktms_pkg::S_COUNT;
				end
			end
			sktms_pkg::S_COUNT: begin
				state_d = sktms_pkg::S_IDLE;
			end
			default: begin
				state_d = sktms_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sweep_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				sktms_pkg::S_APPLY: begin
					done_q <= 1'b1;
					if (ins) begin
						count_q <= count_q + 1'b1;
					end
				end
				sktms_pkg::S_ROUND: begin
					done_q <= 1'b1;
				end
				sktms_pkg::S_KILL: begin
					sweep_cnt_q <= '0;
				end
				sktms_pkg::S_SWAP: begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
				end
				sktms_pkg::S_COUNT: begin
					done_q  <= 1'b1;
					count_q <= enc_val;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= key;
		end
		case (state_q)
			sktms_pkg::S_APPLY: begin
				found_q    <= hit;
				position_q <= (hit || ins) ? sktms_pkg::POS_W'(enc_val) : '0;
				total_q    <= sktms_pkg::TOT_W'(ins ? count_q + 1'b1 : count_q);
				drop_q     <= (func_q == sktms_pkg::FUNC_TOUCH) && !hit && full;
			end
			sktms_pkg::S_ROUND: begin
				found_q    <= 1'b0;
				position_q <= '0;
				total_q    <= sktms_pkg::TOT_W'(count_q);
				drop_q     <= 1'b0;
			end
			sktms_pkg::S_COUNT: begin
				found_q    <= 1'b0;
				position_q <= '0;
				total_q    <= sktms_pkg::TOT_W'(enc_val);
				drop_q     <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign found       = found_q;
	assign position    = position_q;
	assign entry_total = total_q;
	assign full_drop   = drop_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_drop_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && full_drop) |-> !found)
		else $error("drop with hit");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sktms_pkg::S_APPLY && ins) |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow count");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sktms_pkg::S_IDLE) |-> (valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid entries not packed at low end");

endmodule
`default_nettype wire

FILE: tb/sv/tb_sorted_key_table_mark_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table_mark_sweep
// Self-checking bench for the sorted key table: a queue-fed driver issues
// lookup, touch, new-round and sweep items with random idle bursts, a local
// table model predicts each result, and a monitor checks every done strobe.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_mark_sweep;

	localparam int DEPTH_N  = 64;
	localparam int KEY_W    = 22;
	localparam int POOL_N   = 160;
	localparam int ITEMS_N  = 1500;
	localparam int QUIET_AT = 1300;

	typedef struct {
		logic [1:0]       op;
		logic [KEY_W-1:0] k;
		int               gap;
		bit               drain;
	} table_cmd_t;

	typedef struct packed {
		logic                        found;
		logic [sktms_pkg::POS_W-1:0] pos;
		logic [sktms_pkg::TOT_W-1:0] total;
		logic                        drop;
	} table_resp_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic [1:0]                  func = sktms_pkg::FUNC_LOOKUP;
	logic [KEY_W-1:0]            key = '0;
	logic                        busy;
	logic                        done;
	logic                        found;
	logic [sktms_pkg::POS_W-1:0] position;
	logic [sktms_pkg::TOT_W-1:0] entry_total;
	logic                        full_drop;

	table_cmd_t  cmd_q[$];
	table_resp_t resp_q[$];

	logic [KEY_W-1:0] tbl_key [DEPTH_N];
	bit               tbl_fresh [DEPTH_N];
	int               tbl_count;

	int unsigned sent_cnt = 0;
	int unsigned seen_cnt = 0;
	int          errors = 0;
	int          gap_left = 0;
	bit          gap_armed = 1'b0;
	logic [KEY_W-1:0] key_pool [POOL_N];

	sorted_key_table_mark_sweep #(
		.DEPTH   (DEPTH_N),
		.KEY_BITS(KEY_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.key        (key),
		.done       (done),
		.found      (found),
		.position   (position),
		.entry_total(entry_total),
		.full_drop  (full_drop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// table model: apply one item, return the result it produces
	function automatic table_resp_t table_apply(logic [1:0] op, logic [KEY_W-1:0] k);
		table_resp_t r;
		int lo, hi, mid, w;
		bit hit;
		r = '0;
		if (op == sktms_pkg::FUNC_LOOKUP || op == sktms_pkg::FUNC_TOUCH) begin
			lo = 0;
			hi = tbl_count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (tbl_key[mid] < k)
					lo = mid + 1;
				else
					hi = mid;
			end
			hit = (lo < tbl_count) && (tbl_key[lo] == k);
			if (hit) begin
				r.found = 1'b1;
				r.pos = lo[sktms_pkg::POS_W-1:0];
				if (op == sktms_pkg::FUNC_TOUCH)
					tbl_fresh[lo] = 1'b1;
			end else if (op == sktms_pkg::FUNC_TOUCH) begin
				if (tbl_count >= DEPTH_N) begin
					r.drop = 1'b1;
				end else begin
					for (int i = tbl_count; i > lo; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_fresh[i] = tbl_fresh[i-1];
					end
					tbl_key[lo] = k;
					tbl_fresh[lo] = 1'b1;
					tbl_count++;
					r.pos = lo[sktms_pkg::POS_W-1:0];
				end
			end
		end else if (op == sktms_pkg::FUNC_ROUND) begin
			for (int i = 0; i < DEPTH_N; i++)
				tbl_fresh[i] = 1'b0;
		end else begin
			w = 0;
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_fresh[i]) begin
					tbl_key[w] = tbl_key[i];
					tbl_fresh[w] = 1'b1;
					w++;
				end
			end
			for (int i = w; i < tbl_count; i++)
				tbl_fresh[i] = 1'b0;
			tbl_count = w;
		end
		r.total = tbl_count[sktms_pkg::TOT_W-1:0];
		return r;
	endfunction

	task automatic add_cmd(logic [1:0] op, logic [KEY_W-1:0] k, int gap, bit drain);
		table_cmd_t c;
		c.op = op;
		c.k = k;
		c.gap = gap;
		c.drain = drain;
		cmd_q.push_back(c);
	endtask

	task automatic field_err(string name, int want, int got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endtask

	// driver
	always @(posedge clk) begin
		bit take;
		bit launch;
		table_cmd_t c;
		launch = 1'b0;
		if (arst_n) begin
			take = start && !busy;
			if (take) begin
				resp_q.push_back(table_apply(func, key));
				sent_cnt <= sent_cnt + 1;
			end
			if (!start || take) begin
				if (!gap_armed && cmd_q.size() > 0) begin
					gap_left = cmd_q[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_armed) begin
					if (gap_left > 0)
						gap_left--;
					else if (!cmd_q[0].drain || (!take && sent_cnt == seen_cnt))
						launch = 1'b1;
				end
				if (launch) begin
					c = cmd_q.pop_front();
					gap_armed = 1'b0;
					func <= c.op;
					key <= c.k;
				end
				start <= launch;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		table_resp_t want;
		if (arst_n && done) begin
			seen_cnt <= seen_cnt + 1;
			if (resp_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual total %0d",
					$time, entry_total);
			end else begin
				want = resp_q.pop_front();
				if (found !== want.found)
					field_err("found", int'(want.found), int'(found));
				if (position !== want.pos)
					field_err("position", int'(want.pos), int'(position));
				if (entry_total !== want.total)
					field_err("entry_total", int'(want.total), int'(entry_total));
				if (full_drop !== want.drop)
					field_err("full_drop", int'(want.drop), int'(full_drop));
			end
		end
	end

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 4) == 0)
			return KEY_W'($urandom);
		return key_pool[$urandom_range(0, POOL_N - 1)];
	endfunction

	initial begin
		int total;
		int seg_len;
		int mode;
		int r;
		int gap;
		bit idle_on;
		logic [1:0] op;
		logic [KEY_W-1:0] k;

		tbl_count = 0;
		for (int i = 0; i < DEPTH_N; i++) begin
			tbl_key[i] = '0;
			tbl_fresh[i] = 1'b0;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = KEY_W'($urandom);

		// directed
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'd5, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'd100, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'd0, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'h3FFFFF, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'd50, 3, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'd100, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'd50, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'd7, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'h3FFFFF, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'd0, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_ROUND, KEY_W'($urandom), 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'd50, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'd0, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_SWEEP, KEY_W'($urandom), 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'd100, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'd50, 0, 1'b1);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'd25, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_ROUND, KEY_W'($urandom), 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_SWEEP, KEY_W'($urandom), 2, 1'b0);
		add_cmd(sktms_pkg::FUNC_LOOKUP, 22'd0, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_TOUCH, 22'h2AAAAA, 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_SWEEP, KEY_W'($urandom), 0, 1'b0);
		add_cmd(sktms_pkg::FUNC_ROUND, KEY_W'($urandom), 0, 1'b0);
		total = 23;

		// random segments
		while (total < ITEMS_N) begin
			seg_len = $urandom_range(40, 120);
			mode = $urandom_range(0, 3);
			idle_on = ($urandom_range(0, 2) != 0) && (total < QUIET_AT);
			for (int j = 0; j < seg_len && total < ITEMS_N; j++) begin
				r = $urandom_range(0, 99);
				k = pick_key();
				if (mode == 3 && j < 72) begin
					op = sktms_pkg::FUNC_TOUCH;
					k = KEY_W'($urandom);
				end else if (mode == 0) begin
					op = (r < 35) ? sktms_pkg::FUNC_LOOKUP : (r < 75) ? sktms_pkg::FUNC_TOUCH :
						(r < 88) ? sktms_pkg::FUNC_ROUND : sktms_pkg::FUNC_SWEEP;
				end else if (mode == 2) begin
					op = (r < 30) ? sktms_pkg::FUNC_LOOKUP : (r < 60) ? sktms_pkg::FUNC_TOUCH :
						(r < 80) ? sktms_pkg::FUNC_ROUND : sktms_pkg::FUNC_SWEEP;
				end else begin
					op = (r < 25) ? sktms_pkg::FUNC_LOOKUP : (r < 97) ? sktms_pkg::FUNC_TOUCH :
						(r < 99) ? sktms_pkg::FUNC_ROUND : sktms_pkg::FUNC_SWEEP;
				end
				if (total >= QUIET_AT)
					idle_on = 1'b0;
				gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
				add_cmd(op, k, gap,
					(j == 0) && (total < QUIET_AT) && ($urandom_range(0, 1) == 0));
				total++;
			end
		end

		wait (arst_n);
		while (cmd_q.size() != 0 || start || sent_cnt != seen_cnt)
			@(posedge clk);
		repeat (DEPTH_N + 8) @(posedge clk);
		if (errors == 0 && resp_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
sv/sktms_pkg.sv
sv/sktms_cell.sv
sv/sorted_key_table_mark_sweep.sv
tb/sv/tb_sorted_key_table_mark_sweep.sv
